// ===== src/ple_pkg.sv =====
// Shared constants and types for the per-client latency emulator.
// No dependencies; imported by the top level and its port checker.
`timescale 1ns / 1ps

package ple_pkg;

  // Default sizing
  localparam int CLIENTS_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  // Field widths fixed by the interface
  localparam int CLIENT_W  = 3;
  localparam int ELAPSED_W = 8;
  localparam int RAND_W    = 16;
  localparam int CMD_W     = 64;
  localparam int VEC_W     = 32;
  localparam int DELAY_W   = 11;
  localparam int PING_W    = 13;
  localparam int MS_W      = 10;
  localparam int SEC_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Time constants
  localparam logic [MS_W:0]      MS_PER_SEC = 11'd1000;
  localparam logic [DELAY_W-1:0] DELAY_MAX  = 11'd2000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_VAR  = 2'd1;

  // Request actions
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // One queued command with its client timestamp
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VEC_W-1:0] origin_x;
    logic [VEC_W-1:0] origin_y;
    logic [VEC_W-1:0] origin_z;
    logic [VEC_W-1:0] angle_x;
    logic [VEC_W-1:0] angle_y;
    logic [VEC_W-1:0] angle_z;
    logic [SEC_W-1:0] stamp_sec;
    logic [MS_W-1:0]  stamp_ms;
  } entry_t;

  // Saturate a register write to the delay limit
  function automatic logic [DELAY_W-1:0] clamp_reg(input logic [DELAY_W-1:0] v);
    clamp_reg = (v > DELAY_MAX) ? DELAY_MAX : v;
  endfunction

endpackage

// ===== src/per_client_latency_emulator.sv =====
// Per-client latency emulator: per-client clocks, delay redraw and delay queues.
// Depends on ple_pkg; the entry memory lives inside this module.
//
// Usage:
//   Requests enter on start while busy is low (busy never rises, so a request
//   may enter every cycle). in_action selects store (queue a command with the
//   client's timestamp, advancing its clock) or fetch (release the head entry
//   once its delay has passed).
//   Each request yields exactly one result, shown for one cycle with out_valid
//   once it has passed the stage-two registers and the result register;
//   results come out in request order.
//   Stage one reads the head and next-to-head entries of the entry memory
//   (registered read port pair); stage two updates the client state, writes
//   the memory and loads the result register. The entry memory has one write
//   port; throughput is one request a cycle.
//   The receiver cannot stall: out_valid is a strobe and must be taken.
//   The cfg port (index, data, valid/ready) writes base delay and variance;
//   cfg_ready is always high and writes are meant only while no request is
//   in flight. A base delay write also resets every client's current delay.
//   Reset (rst_n low, synchronous) empties all queues and clears clocks,
//   pings, delays and both registers; the entry memory is not cleared.
`timescale 1ns / 1ps

module per_client_latency_emulator #(
  parameter int CLIENTS     = ple_pkg::CLIENTS_DEF,
  parameter int QUEUE_DEPTH = ple_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_action,
  input  logic [ple_pkg::CLIENT_W-1:0]       in_client,
  input  logic [ple_pkg::ELAPSED_W-1:0]      in_elapsed_ms,
  input  logic signed [ple_pkg::RAND_W-1:0]  in_rand_sample,
  input  logic [ple_pkg::CMD_W-1:0]          in_cmd_word,
  input  logic [ple_pkg::VEC_W-1:0]          in_origin_x,
  input  logic [ple_pkg::VEC_W-1:0]          in_origin_y,
  input  logic [ple_pkg::VEC_W-1:0]          in_origin_z,
  input  logic [ple_pkg::VEC_W-1:0]          in_angle_x,
  input  logic [ple_pkg::VEC_W-1:0]          in_angle_y,
  input  logic [ple_pkg::VEC_W-1:0]          in_angle_z,
  // result channel
  output logic                               out_valid,
  output logic                               out_released,
  output logic [ple_pkg::CMD_W-1:0]          out_cmd_out,
  output logic [ple_pkg::VEC_W-1:0]          out_origin_out_x,
  output logic [ple_pkg::VEC_W-1:0]          out_origin_out_y,
  output logic [ple_pkg::VEC_W-1:0]          out_origin_out_z,
  output logic [ple_pkg::VEC_W-1:0]          out_angle_out_x,
  output logic [ple_pkg::VEC_W-1:0]          out_angle_out_y,
  output logic [ple_pkg::VEC_W-1:0]          out_angle_out_z,
  output logic [ple_pkg::DELAY_W-1:0]        out_current_delay,
  output logic signed [ple_pkg::PING_W-1:0]  out_ping_value,
  output logic                               out_overflow,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ple_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ple_pkg::DELAY_W-1:0]        cfg_data
);

  import ple_pkg::*;

  localparam int CW    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int NW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = CLIENTS * QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = RAND_W + DELAY_W + 1;

  // ---------------- configuration and per-client state ----------------
  logic [DELAY_W-1:0]        base_r;
  logic [DELAY_W-1:0]        var_r;
  logic [SEC_W-1:0]          sec_r   [CLIENTS];
  logic [MS_W-1:0]           ms_r    [CLIENTS];
  logic [DELAY_W-1:0]        delay_r [CLIENTS];
  logic signed [PING_W-1:0]  ping_r  [CLIENTS];
  logic [QW-1:0]             head_r  [CLIENTS];
  logic [NW-1:0]             count_r [CLIENTS];

  entry_t                    mem [DEPTH];

  // ---------------- stage one: accept and read ----------------
  logic                      accept;
  logic                      in_ok;
  logic [CW-1:0]             cidx_in;
  logic [QW-1:0]             head_in;
  logic [QW-1:0]             head_next_in;
  logic [AW-1:0]             addr_h;
  logic [AW-1:0]             addr_n;
  logic signed [PW-1:0]      prod_s0;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  assign in_ok        = (32'(in_client) < 32'(CLIENTS));
  assign cidx_in      = in_ok ? CW'(in_client) : '0;
  assign head_in      = head_r[cidx_in];
  assign head_next_in = (head_in == QW'(QUEUE_DEPTH - 1)) ? '0 : head_in + QW'(1);
  assign addr_h       = AW'(int'(cidx_in) * QUEUE_DEPTH + int'(head_in));
  assign addr_n       = AW'(int'(cidx_in) * QUEUE_DEPTH + int'(head_next_in));
  assign prod_s0      = PW'(in_rand_sample) * PW'($signed({1'b0, var_r}));

  // stage-two registers
  logic                      v1_r;
  logic                      ok1_r;
  logic                      act1_r;
  logic [CW-1:0]             cidx1_r;
  logic [QW-1:0]             head1_r;
  logic [ELAPSED_W-1:0]      elapsed1_r;
  logic signed [PW-1:0]      prod1_r;
  entry_t                    req1_r;
  entry_t                    rd_h_r;
  entry_t                    rd_n_r;

  // write port signals driven by stage two
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  entry_t                    wr_data;

  // Hold the request in stage two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok1_r            <= in_ok;
      act1_r           <= in_action;
      cidx1_r          <= cidx_in;
      head1_r          <= head_in;
      elapsed1_r       <= in_elapsed_ms;
      prod1_r          <= prod_s0;
      req1_r.cmd       <= in_cmd_word;
      req1_r.origin_x  <= in_origin_x;
      req1_r.origin_y  <= in_origin_y;
      req1_r.origin_z  <= in_origin_z;
      req1_r.angle_x   <= in_angle_x;
      req1_r.angle_y   <= in_angle_y;
      req1_r.angle_z   <= in_angle_z;
      req1_r.stamp_sec <= '0;
      req1_r.stamp_ms  <= '0;
    end
  end

  // Entry memory: one write, two registered reads, write data forwarded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_h_r <= (wr_en && wr_addr == addr_h) ? wr_data : mem[addr_h];
      rd_n_r <= (wr_en && wr_addr == addr_n) ? wr_data : mem[addr_n];
    end
  end

  // ---------------- stage two: update and decide ----------------
  logic [QW-1:0]             head_c;
  logic [NW-1:0]             cnt_c;
  logic [MS_W-1:0]           ms_c;
  logic [SEC_W-1:0]          sec_c;
  logic [DELAY_W-1:0]        delay_c;
  logic signed [PING_W-1:0]  ping_c;
  entry_t                    head_entry;
  logic                      is_store;
  logic                      is_fetch;

  assign head_c   = head_r[cidx1_r];
  assign cnt_c    = count_r[cidx1_r];
  assign ms_c     = ms_r[cidx1_r];
  assign sec_c    = sec_r[cidx1_r];
  assign delay_c  = delay_r[cidx1_r];
  assign ping_c   = ping_r[cidx1_r];
  assign is_store = v1_r & ok1_r & (act1_r == ACT_STORE);
  assign is_fetch = v1_r & ok1_r & (act1_r == ACT_FETCH);

  // Pick the next-to-head copy when the previous request just popped
  assign head_entry = (head1_r == head_c) ? rd_h_r : rd_n_r;

  // Advance the client clock, one rollover at most
  logic [MS_W:0]             ms_sum;
  logic                      roll;
  logic [MS_W-1:0]           ms_new;
  logic [SEC_W-1:0]          sec_new;

  assign ms_sum  = {1'b0, ms_c} + (MS_W + 1)'(elapsed1_r);
  assign roll    = ms_sum > MS_PER_SEC;
  assign ms_new  = roll ? MS_W'(ms_sum - MS_PER_SEC) : MS_W'(ms_sum);
  assign sec_new = sec_c + SEC_W'(roll);

  // Redraw the delay: base + product >> 15, truncated toward zero
  logic                      prod_neg;
  logic [PW-1:0]             prod_mag;
  logic [DELAY_W:0]          term_mag;
  logic [PING_W-1:0]         term;
  logic signed [PING_W-1:0]  raw;
  logic [DELAY_W-1:0]        raw_clamped;

  assign prod_neg    = prod1_r[PW-1];
  assign prod_mag    = prod_neg ? PW'(-prod1_r) : PW'(prod1_r);
  assign term_mag    = (DELAY_W + 1)'(prod_mag >> 15);
  assign term        = prod_neg ? PING_W'(-{1'b0, term_mag}) : PING_W'({1'b0, term_mag});
  assign raw         = $signed(PING_W'({2'b00, base_r}) + term);
  assign raw_clamped = raw[PING_W-1] ? '0 :
                       (raw > $signed({2'b00, DELAY_MAX})) ? DELAY_MAX :
                       raw[DELAY_W-1:0];

  // Enqueue at the tail unless full
  logic                      full;
  logic [QW:0]               slot_sum;
  logic [QW-1:0]             slot;

  assign full     = (cnt_c == NW'(QUEUE_DEPTH));
  assign slot_sum = {1'b0, head_c} + (QW + 1)'(cnt_c);
  assign slot     = (slot_sum >= (QW + 1)'(QUEUE_DEPTH)) ?
                    QW'(slot_sum - (QW + 1)'(QUEUE_DEPTH)) : QW'(slot_sum);

  assign wr_en   = is_store & ~full;
  assign wr_addr = AW'(int'(cidx1_r) * QUEUE_DEPTH + int'(slot));

  always_comb begin
    wr_data           = req1_r;
    wr_data.stamp_sec = sec_new;
    wr_data.stamp_ms  = ms_new;
  end

  // Release check: elapsed since stamp >= delay - 1
  logic [SEC_W-1:0]          dsec;
  logic                      far;
  logic [DELAY_W:0]          sec_ms;
  logic signed [PING_W-1:0]  sdiff_p1;
  logic                      due;
  logic                      release_hit;
  logic [QW-1:0]             head_adv;

  assign dsec   = sec_c - head_entry.stamp_sec;
  assign far    = (dsec > SEC_W'(2));
  assign sec_ms = (dsec[1:0] == 2'd0) ? '0 :
                  (dsec[1:0] == 2'd1) ? (DELAY_W + 1)'(MS_PER_SEC) :
                                        (DELAY_W + 1)'(DELAY_MAX);
  assign sdiff_p1 = $signed(PING_W'({1'b0, sec_ms}) + PING_W'(ms_c)
                            - PING_W'(head_entry.stamp_ms) + PING_W'(1));
  assign due         = far | (sdiff_p1 >= $signed({2'b00, delay_c}));
  assign release_hit = is_fetch & (cnt_c != '0) & due;
  assign head_adv    = (head_c == QW'(QUEUE_DEPTH - 1)) ? '0 : head_c + QW'(1);

  // Update configuration and client state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      var_r  <= '0;
      for (int c = 0; c < CLIENTS; c++) begin
        sec_r[c]   <= '0;
        ms_r[c]    <= '0;
        delay_r[c] <= '0;
        ping_r[c]  <= '0;
        head_r[c]  <= '0;
        count_r[c] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_DELAY: begin
            base_r <= clamp_reg(cfg_data);
            for (int c = 0; c < CLIENTS; c++) begin
              delay_r[c] <= clamp_reg(cfg_data);
            end
          end
          REG_DELAY_VAR: begin
            var_r <= clamp_reg(cfg_data);
          end
          default: begin
          end
        endcase
      end
      if (is_store) begin
        ms_r[cidx1_r]  <= ms_new;
        sec_r[cidx1_r] <= sec_new;
        if (roll) begin
          ping_r[cidx1_r]  <= raw;
          delay_r[cidx1_r] <= raw_clamped;
        end
        if (!full) begin
          count_r[cidx1_r] <= cnt_c + NW'(1);
        end
      end else if (release_hit) begin
        head_r[cidx1_r]  <= head_adv;
        count_r[cidx1_r] <= cnt_c - NW'(1);
      end
    end
  end

  // ---------------- result register ----------------
  logic                      out_valid_r;
  logic                      released_r;
  entry_t                    out_entry_r;
  logic [DELAY_W-1:0]        cur_delay_r;
  logic signed [PING_W-1:0]  ping_out_r;
  logic                      overflow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v1_r;
    end
  end

  // Load the result; zero every field for an out-of-range client
  always_ff @(posedge clk) begin
    released_r  <= release_hit;
    out_entry_r <= release_hit ? head_entry : '0;
    overflow_r  <= is_store & full;
    if (!ok1_r) begin
      cur_delay_r <= '0;
      ping_out_r  <= '0;
    end else if (is_store && roll) begin
      cur_delay_r <= raw_clamped;
      ping_out_r  <= raw;
    end else begin
      cur_delay_r <= delay_c;
      ping_out_r  <= ping_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_released      = released_r;
  assign out_cmd_out       = out_entry_r.cmd;
  assign out_origin_out_x  = out_entry_r.origin_x;
  assign out_origin_out_y  = out_entry_r.origin_y;
  assign out_origin_out_z  = out_entry_r.origin_z;
  assign out_angle_out_x   = out_entry_r.angle_x;
  assign out_angle_out_y   = out_entry_r.angle_y;
  assign out_angle_out_z   = out_entry_r.angle_z;
  assign out_current_delay = cur_delay_r;
  assign out_ping_value    = ping_out_r;
  assign out_overflow      = overflow_r;

endmodule

// ===== src/ple_checker.sv =====
// Port-level checker for the per-client latency emulator, with its bind.
// Depends on ple_pkg and attaches to per_client_latency_emulator.
`timescale 1ns / 1ps

module ple_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic                               out_released,
  input logic                               out_overflow,
  input logic [ple_pkg::CMD_W-1:0]          out_cmd_out,
  input logic [ple_pkg::VEC_W-1:0]          out_origin_out_x,
  input logic [ple_pkg::DELAY_W-1:0]        out_current_delay
);

  import ple_pkg::*;

  // Every result traces back to an accepted request
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a request");

  // Every accepted request yields its result
  a_request_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(start && !busy && rst_n, 2) && $past(rst_n)) |-> out_valid)
    else $error("request lost");

  // A request cannot both release and drop
  a_release_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_released && out_overflow))
    else $error("release and overflow together");

  // No release means an empty payload
  a_empty_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_released) |-> (out_cmd_out == '0 && out_origin_out_x == '0))
    else $error("payload without release");

  // Reported delay stays within its clamp
  a_delay_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_current_delay <= DELAY_MAX))
    else $error("delay above limit");

endmodule

bind per_client_latency_emulator ple_checker u_ple_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_released      (out_released),
  .out_overflow      (out_overflow),
  .out_cmd_out       (out_cmd_out),
  .out_origin_out_x  (out_origin_out_x),
  .out_current_delay (out_current_delay)
);
